>>> rtl/core/pme_pkg.sv
// Shared types, constants and helpers for the pheromone matrix engine.
package pme_pkg;
  localparam int MaxCities = 64;
  localparam int FracBits = 16;
  localparam int CityW = $clog2(MaxCities);
  localparam int AddrW = 2 * CityW;
  localparam int Depth = MaxCities * MaxCities;
  localparam int LevelW = 32;
  localparam logic [16:0] OneQ16 = 17'h10000;

  localparam logic [6:0] NumCitiesRst = 7'd64;
  localparam logic [16:0] EvapRateRst = 17'd6554;
  localparam logic [31:0] MinLevelRst = 32'd1;

  typedef enum logic [1:0] {
    REG_NUM_CITIES = 2'd0,
    REG_EVAP_RATE  = 2'd1,
    REG_MIN_LEVEL  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_FILL    = 3'd2,
    CMD_EVAP    = 3'd3,
    CMD_DEPOSIT = 3'd4,
    CMD_ADD     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_BADTOUR = 2'd2
  } status_t;

  typedef struct packed {
    logic        start;
    logic [31:0] quality;
    logic [31:0] length;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

>>> rtl/core/pme_ram.sv
// Edge level memory, one write port and one registered read port.
module pme_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [pme_pkg::AddrW-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic [pme_pkg::AddrW-1:0] raddr,
  output logic [31:0]              rdata
);
  logic [31:0] mem [pme_pkg::Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/pme_div.sv
// Restoring divider for the deposit amount, (Q << FRAC) / length, saturated.
module pme_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pme_pkg::div_req_t req,
  output pme_pkg::div_rsp_t rsp
);
  localparam int NumW = 32 + pme_pkg::FracBits;

  logic [NumW-1:0] num_r, num_nxt;
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [31:0]     den_r, den_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [33:0]     trial;
  logic [32:0]     shifted;

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[31:0], num_r[NumW-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    if (req.start) begin
      num_nxt  = {req.quality, {pme_pkg::FracBits{1'b0}}};
      den_nxt  = req.length;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = 6'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NumW-2:0], 1'b0};
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = (|quo_r[NumW-1:32]) ? 32'hFFFF_FFFF : quo_r[31:0];
endmodule

>>> rtl/core/pheromone_matrix_engine.sv
// Pheromone matrix engine: command sequencer around the edge level memory.
// A first tour city waits for the bit-serial divider; fill and evaporate sweep the n*n active entries.
// One item at a time; the next beat can be taken in the cycle after the result is registered.
// A waiting result stalls the sequencer only when the next result is ready to register.
// Synchronous active-low reset restores control and configuration defaults; matrix undefined until written.
module pheromone_matrix_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: cmd[2:0], from_city[8:3], to_city[14:9], value[46:15],
  // path_len[78:47], quality[110:79], zero pad [111]
  input  logic [111:0] in_tdata,
  // tuser: tour_first[0]
  input  logic        in_tuser,
  // tlast: tour_last
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: read_value[31:0], status[33:32], zero pad [39:34]
  output logic [39:0] out_tdata
);
  localparam int CW = pme_pkg::CityW;
  localparam int AW = pme_pkg::AddrW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD     = 9'b000000010,
    S_MOD    = 9'b000000100,
    S_SWEEP  = 9'b000001000,
    S_EVRD   = 9'b000010000,
    S_EVMUL  = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_CLOSE  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]  num_cities_r;
  logic [16:0] evap_rate_r;
  logic [31:0] min_level_r;

  logic [2:0]  cmd_r;
  logic [CW-1:0] row_r, col_r;
  logic [31:0] value_r;
  logic        first_r;
  logic        last_r;
  logic [CW-1:0] swr_r, swc_r;
  logic [31:0] prod_r;

  logic [31:0] dep_amt_r;
  logic [CW-1:0] start_r, prev_r;
  logic        open_r;

  logic        ovalid_r;
  logic [31:0] ord_r;
  logic [1:0]  ost_r;
  logic [31:0] hrd_r;
  logic [1:0]  hst_r;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  pme_pkg::div_req_t dreq;
  pme_pkg::div_rsp_t drsp;

  pme_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                 .raddr(raddr), .rdata(rdata));
  pme_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [6:0] side;
  always_comb begin
    if (num_cities_r == 7'd0) side = 7'd1;
    else if (num_cities_r > 7'(pme_pkg::MaxCities)) side = 7'(pme_pkg::MaxCities);
    else side = num_cities_r;
  end

  logic [16:0] keep;
  assign keep = (evap_rate_r > pme_pkg::OneQ16) ? 17'd0 : pme_pkg::OneQ16 - evap_rate_r;

  function automatic logic [31:0] floor_lvl(input logic [31:0] v, input logic [31:0] m);
    floor_lvl = (v < m) ? m : v;
  endfunction

  logic [31:0] sval;
  assign sval = value_r[31] ? min_level_r : floor_lvl(value_r, min_level_r);

  logic in_rng;
  assign in_rng = ({1'b0, row_r} < side) && ({1'b0, col_r} < side);

  logic [33:0] addsum;
  logic [31:0] addres, depres;
  logic [32:0] dsum;
  always_comb begin
    addsum = {2'b00, rdata} + {{2{value_r[31]}}, value_r};
    if (addsum[33]) addres = 32'd0;
    else if (addsum[32]) addres = 32'hFFFF_FFFF;
    else addres = addsum[31:0];
    addres = floor_lvl(addres, min_level_r);
    dsum = {1'b0, rdata} + {1'b0, dep_amt_r};
    depres = floor_lvl(dsum[32] ? 32'hFFFF_FFFF : dsum[31:0], min_level_r);
  end

  logic [48:0] mul;
  assign mul = rdata * keep;

  logic accept, out_free;
  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, ost_r, ord_r};

  logic sweep_end;
  assign sweep_end = ({1'b0, swr_r} == side - 7'd1) && ({1'b0, swc_r} == side - 7'd1);

  logic        res_v;
  logic        out_load;
  logic [31:0] res_rd;
  logic [1:0]  res_st;
  logic [CW-1:0] swr_nxt, swc_nxt;
  logic [31:0] dep_nxt;
  logic [CW-1:0] start_nxt, prev_nxt;
  logic open_nxt;

  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    waddr = {row_r, col_r};
    wdata = sval;
    raddr = {row_r, col_r};
    res_v = 1'b0;
    out_load = 1'b0;
    res_rd = 32'd0;
    res_st = pme_pkg::ST_OK;
    swr_nxt = swr_r;
    swc_nxt = swc_r;
    dep_nxt = dep_amt_r;
    start_nxt = start_r;
    prev_nxt = prev_r;
    open_nxt = open_r;
    dreq.start = 1'b0;
    dreq.quality = value_r;
    dreq.length = prod_r;
    if (sweep_end) begin
      swr_nxt = '0;
      swc_nxt = '0;
    end else if ({1'b0, swc_r} == side - 7'd1) begin
      swr_nxt = swr_r + 1'b1;
      swc_nxt = '0;
    end else begin
      swc_nxt = swc_r + 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_RD;
        swr_nxt = '0;
        swc_nxt = '0;
      end
      S_RD: begin
        swr_nxt = '0;
        swc_nxt = '0;
        state_nxt = S_OUT;
        case (cmd_r)
          pme_pkg::CMD_READ, pme_pkg::CMD_ADD: begin
            if (in_rng) state_nxt = S_MOD;
            else res_st = pme_pkg::ST_RANGE;
          end
          pme_pkg::CMD_WRITE: begin
            if (in_rng) we = 1'b1;
            else res_st = pme_pkg::ST_RANGE;
          end
          pme_pkg::CMD_FILL: state_nxt = S_SWEEP;
          pme_pkg::CMD_EVAP: begin
            raddr = '0;
            state_nxt = S_EVRD;
          end
          pme_pkg::CMD_DEPOSIT: begin
            if (first_r) begin
              open_nxt = 1'b0;
              if (last_r || prod_r == 32'd0) res_st = pme_pkg::ST_BADTOUR;
              else if ({1'b0, col_r} >= side) res_st = pme_pkg::ST_RANGE;
              else begin
                dreq.start = 1'b1;
                start_nxt = col_r;
                prev_nxt = col_r;
                state_nxt = S_DIV;
              end
            end else if (!open_r) begin
              res_st = pme_pkg::ST_BADTOUR;
            end else if ({1'b0, col_r} >= side || {1'b0, prev_r} >= side) begin
              open_nxt = 1'b0;
              res_st = pme_pkg::ST_RANGE;
            end else begin
              raddr = {prev_r, col_r};
              state_nxt = S_MOD;
            end
          end
          default: ;
        endcase
        if (state_nxt == S_OUT) res_v = 1'b1;
      end
      S_MOD: begin
        state_nxt = S_OUT;
        if (cmd_r == pme_pkg::CMD_READ) begin
          res_rd = rdata;
        end else if (cmd_r == pme_pkg::CMD_ADD) begin
          we = value_r != 32'd0;
          wdata = addres;
        end else begin
          we = 1'b1;
          waddr = {prev_r, col_r};
          wdata = depres;
          prev_nxt = col_r;
          if (last_r) begin
            open_nxt = 1'b0;
            if ({1'b0, start_r} >= side) res_st = pme_pkg::ST_RANGE;
            else begin
              raddr = {col_r, start_r};
              state_nxt = S_CLOSE;
            end
          end
        end
        res_v = state_nxt == S_OUT;
      end
      S_CLOSE: begin
        raddr = {col_r, start_r};
        state_nxt = S_EVMUL;
      end
      S_EVMUL: begin
        if (cmd_r == pme_pkg::CMD_DEPOSIT) begin
          we = 1'b1;
          waddr = {col_r, start_r};
          wdata = depres;
          res_v = 1'b1;
          state_nxt = S_OUT;
        end else begin
          we = 1'b1;
          waddr = {swr_r, swc_r};
          wdata = floor_lvl(prod_r, min_level_r);
          swr_nxt = swr_r;
          swc_nxt = swc_r;
          if (sweep_end) begin
            res_v = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_EVRD;
            if ({1'b0, swc_r} == side - 7'd1) begin
              swr_nxt = swr_r + 1'b1;
              swc_nxt = '0;
            end else swc_nxt = swc_r + 1'b1;
            raddr = {swr_nxt, swc_nxt};
          end
        end
      end
      S_EVRD: begin
        raddr = {swr_r, swc_r};
        swr_nxt = swr_r;
        swc_nxt = swc_r;
        state_nxt = S_EVMUL;
      end
      S_SWEEP: begin
        we = 1'b1;
        waddr = {swr_r, swc_r};
        if (sweep_end) begin
          res_v = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          dep_nxt = drsp.quotient;
          open_nxt = 1'b1;
          res_v = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_cities_r <= pme_pkg::NumCitiesRst;
      evap_rate_r  <= pme_pkg::EvapRateRst;
      min_level_r  <= pme_pkg::MinLevelRst;
      dep_amt_r    <= '0;
      start_r      <= '0;
      prev_r       <= '0;
      open_r       <= 1'b0;
      ovalid_r     <= 1'b0;
      swr_r        <= '0;
      swc_r        <= '0;
    end else begin
      state_r  <= state_nxt;
      dep_amt_r <= dep_nxt;
      start_r  <= start_nxt;
      prev_r   <= prev_nxt;
      open_r   <= open_nxt;
      swr_r    <= swr_nxt;
      swc_r    <= swc_nxt;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          pme_pkg::REG_NUM_CITIES: num_cities_r <= cfg_wdata[6:0];
          pme_pkg::REG_EVAP_RATE:  evap_rate_r <= cfg_wdata[16:0];
          pme_pkg::REG_MIN_LEVEL:  min_level_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (res_v) begin
      hrd_r <= res_rd;
      hst_r <= res_st;
    end
    if (out_load) begin
      ord_r <= hrd_r;
      ost_r <= hst_r;
    end
    if (accept) begin
      cmd_r   <= in_tdata[2:0];
      row_r   <= in_tdata[8:3];
      col_r   <= in_tdata[14:9];
      first_r <= in_tuser;
      last_r  <= in_tlast;
      value_r <= (in_tdata[2:0] == pme_pkg::CMD_DEPOSIT) ? in_tdata[110:79]
                                                         : in_tdata[46:15];
      prod_r  <= in_tdata[78:47];
    end else if (state_r == S_EVRD) begin
      prod_r <= mul[47:16];
    end
  end
endmodule

>>> sim/tb_pheromone_matrix_engine.sv
// Self-checking testbench for the pheromone matrix engine: random commands, tours and stalls.
module tb_pheromone_matrix_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam logic [2:0] CmdSpareA = 3'd6;
  localparam logic [2:0] CmdSpareB = 3'd7;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [31:0] quality;
    logic [31:0] tlen;
    logic [31:0] value;
    logic [5:0]  to_city;
    logic [5:0]  from_city;
    logic [2:0]  cmd;
  } cmd_beat_t;

  typedef struct packed {
    logic [31:0] rd;
    logic [1:0]  st;
  } result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic in_tuser = 0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;

  pheromone_matrix_engine dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial forever #6 clk = ~clk;

  // predictor state
  logic [31:0] lvl [pme_pkg::Depth];
  logic [6:0]  side_reg = pme_pkg::NumCitiesRst;
  logic [16:0] rho_reg = pme_pkg::EvapRateRst;
  logic [31:0] floor_reg = pme_pkg::MinLevelRst;
  logic [31:0] dep_amt;
  logic [5:0]  tour_start, tour_prev;
  bit          tour_on;

  cmd_beat_t pending_q[$];
  result_t   expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_send = 0;
  int sides [5] = '{64, 1, 5, 13, 64};
  int counts [5] = '{70, 90, 90, 90, 70};

  function automatic int side();
    if (side_reg == 7'd0) return 1;
    if (side_reg > 7'(pme_pkg::MaxCities)) return pme_pkg::MaxCities;
    return int'(side_reg);
  endfunction

  function automatic int slot(int r, int c);
    return r * pme_pkg::MaxCities + c;
  endfunction

  function automatic logic [31:0] floored(logic [31:0] v);
    return v < floor_reg ? floor_reg : v;
  endfunction

  function automatic void add_sat(int r, int c, logic [31:0] a);
    logic [32:0] s;
    s = {1'b0, lvl[slot(r, c)]} + {1'b0, a};
    lvl[slot(r, c)] = floored(s[32] ? 32'hFFFF_FFFF : s[31:0]);
  endfunction

  function automatic logic [1:0] predict_deposit(cmd_beat_t b, int n);
    logic [63:0] q;
    if (b.first) begin
      tour_on = 0;
      if (b.last || b.tlen == 0) return pme_pkg::ST_BADTOUR;
      if (b.to_city >= n) return pme_pkg::ST_RANGE;
      q = {b.quality, 16'h0} / {32'h0, b.tlen};
      dep_amt = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
      tour_start = b.to_city;
      tour_prev = b.to_city;
      tour_on = 1;
      return pme_pkg::ST_OK;
    end
    if (!tour_on) return pme_pkg::ST_BADTOUR;
    if (b.to_city >= n || tour_prev >= n) begin
      tour_on = 0;
      return pme_pkg::ST_RANGE;
    end
    add_sat(tour_prev, b.to_city, dep_amt);
    tour_prev = b.to_city;
    if (b.last) begin
      tour_on = 0;
      if (tour_start >= n) return pme_pkg::ST_RANGE;
      add_sat(b.to_city, tour_start, dep_amt);
    end
    return pme_pkg::ST_OK;
  endfunction

  function automatic result_t predict_level(cmd_beat_t b);
    result_t r;
    int n;
    bit ok;
    logic [16:0] keep;
    logic [63:0] p;
    longint s;
    n = side();
    ok = b.from_city < n && b.to_city < n;
    r = '0;
    case (b.cmd)
      pme_pkg::CMD_READ: begin
        if (ok) r.rd = lvl[slot(b.from_city, b.to_city)];
        else r.st = pme_pkg::ST_RANGE;
      end
      pme_pkg::CMD_WRITE: begin
        if (ok) lvl[slot(b.from_city, b.to_city)] = b.value[31] ? floor_reg : floored(b.value);
        else r.st = pme_pkg::ST_RANGE;
      end
      pme_pkg::CMD_FILL:
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            lvl[slot(i, j)] = b.value[31] ? floor_reg : floored(b.value);
      pme_pkg::CMD_EVAP: begin
        keep = pme_pkg::OneQ16 - (rho_reg > pme_pkg::OneQ16 ? pme_pkg::OneQ16 : rho_reg);
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            p = lvl[slot(i, j)] * keep;
            lvl[slot(i, j)] = floored(p[47:16]);
          end
      end
      pme_pkg::CMD_DEPOSIT: r.st = predict_deposit(b, n);
      pme_pkg::CMD_ADD: begin
        if (!ok) r.st = pme_pkg::ST_RANGE;
        else if (b.value != 0) begin
          s = longint'(lvl[slot(b.from_city, b.to_city)]) + longint'($signed(b.value));
          if (s < 0) s = 0;
          if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
          lvl[slot(b.from_city, b.to_city)] = floored(s[31:0]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: bursts with gaps
  int gap = 0;
  int burst = 0;
  always @(posedge clk) begin
    cmd_beat_t b;
    logic fire;
    fire = in_tvalid && in_tready;
    if (fire) begin
      b = pending_q.pop_front();
      expected_q.push_back(predict_level(b));
    end
    if (!in_tvalid || fire) begin
      if (rst_n && !hold_send && pending_q.size() > 0 && gap == 0) begin
        b = pending_q[0];
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, b.quality, b.tlen, b.value, b.to_city, b.from_city, b.cmd};
        in_tuser <= b.first;
        in_tlast <= b.last;
        if (burst > 0) burst <= burst - 1;
        else begin
          burst <= int'($urandom_range(0, 12));
          gap <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
        end
      end else begin
        in_tvalid <= 1'b0;
        if (gap > 0) gap <= gap - 1;
      end
    end
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // monitor with its own stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    result_t got;
    result_t want;
    stall_phase <= stall_phase + 1;
    out_tready <= rst_n && ((stall_phase % 11) < 7 || $urandom_range(0, 3) == 0);
    if (out_tvalid && out_tready) begin
      got.rd = out_tdata[31:0];
      got.st = out_tdata[33:32];
      if (expected_q.size() == 0) report("result with nothing expected");
      else begin
        want = expected_q.pop_front();
        if (got.rd !== want.rd)
          report($sformatf("read_value got %h want %h", got.rd, want.rd));
        if (got.st !== want.st)
          report($sformatf("status got %0d want %0d", got.st, want.st));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus helpers: only touch entries already written
  function automatic cmd_beat_t mk(logic [2:0] c, int r, int k, logic [31:0] v);
    cmd_beat_t b;
    b = '0;
    b.cmd = c;
    b.from_city = 6'(r);
    b.to_city = 6'(k);
    b.value = v;
    b.first = 1'($urandom_range(0, 1));
    b.last = 1'($urandom_range(0, 1));
    b.quality = $urandom();
    b.tlen = $urandom();
    return b;
  endfunction

  function automatic cmd_beat_t mk_city(int city, bit f, bit l, logic [31:0] q,
                                        logic [31:0] len);
    cmd_beat_t b;
    b = mk(pme_pkg::CMD_DEPOSIT, int'($urandom_range(0, 63)), city, $urandom());
    b.first = f;
    b.last = l;
    b.quality = q;
    b.tlen = len;
    return b;
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(pme_pkg::reg_idx_t idx, logic [31:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    case (idx)
      pme_pkg::REG_NUM_CITIES: side_reg = d[6:0];
      pme_pkg::REG_EVAP_RATE:  rho_reg = d[16:0];
      default:                 floor_reg = d;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic int rnd_city(int n);
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 63))
                                        : int'($urandom_range(0, n - 1));
  endfunction

  task automatic push_tour(int n);
    int len;
    len = int'($urandom_range(2, 6));
    for (int i = 0; i < len; i++)
      pending_q.push_back(mk_city(rnd_city(n), i == 0, i == len - 1,
                                  $urandom(), $urandom_range(0, 5) == 0 ? $urandom_range(1, 9)
                                  : $urandom()));
  endtask

  task automatic push_random(int count, int n);
    int c;
    for (int k = 0; k < count; k++) begin
      c = int'($urandom_range(0, 19));
      if (c < 4) push_tour(n);
      else if (c < 7) pending_q.push_back(mk(pme_pkg::CMD_READ, rnd_city(n), rnd_city(n), 0));
      else if (c < 10)
        pending_q.push_back(mk(pme_pkg::CMD_WRITE, rnd_city(n), rnd_city(n), rnd_val()));
      else if (c < 14)
        pending_q.push_back(mk(pme_pkg::CMD_ADD, rnd_city(n), rnd_city(n), rnd_val()));
      else if (c == 14) pending_q.push_back(mk(pme_pkg::CMD_EVAP, 0, 0, 0));
      else if (c == 15) pending_q.push_back(mk(pme_pkg::CMD_FILL, 0, 0, rnd_val()));
      else if (c == 16)
        pending_q.push_back(mk(($urandom_range(0, 1) == 0) ? CmdSpareA : CmdSpareB,
                               int'($urandom_range(0, 63)), int'($urandom_range(0, 63)),
                               $urandom()));
      else if (c == 17)
        pending_q.push_back(mk_city(rnd_city(n), 1'b1, 1'($urandom_range(0, 1)),
                                    $urandom(), $urandom_range(0, 1)));
      else pending_q.push_back(mk_city(rnd_city(n), 1'b0, 1'($urandom_range(0, 1)),
                                       32'd0, 32'd0));
    end
  endtask

  initial begin
    dep_amt = '0;
    tour_start = '0;
    tour_prev = '0;
    tour_on = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: fill first so every entry is defined
    pending_q.push_back(mk(pme_pkg::CMD_FILL, 0, 0, 32'h0001_0000));
    pending_q.push_back(mk(pme_pkg::CMD_READ, 63, 63, 0));
    pending_q.push_back(mk(pme_pkg::CMD_WRITE, 0, 0, 32'h8000_0000));
    pending_q.push_back(mk(pme_pkg::CMD_WRITE, 63, 0, 32'h7FFF_FFFF));
    pending_q.push_back(mk(pme_pkg::CMD_ADD, 63, 0, 32'h7FFF_FFFF));
    pending_q.push_back(mk(pme_pkg::CMD_ADD, 63, 0, 32'h7FFF_FFFF));
    pending_q.push_back(mk(pme_pkg::CMD_ADD, 0, 0, 32'h8000_0000));
    pending_q.push_back(mk(pme_pkg::CMD_ADD, 1, 1, 0));
    pending_q.push_back(mk(pme_pkg::CMD_EVAP, 0, 0, 0));
    pending_q.push_back(mk(pme_pkg::CMD_READ, 63, 0, 0));
    pending_q.push_back(mk(CmdSpareA, 63, 63, 32'hFFFF_FFFF));
    pending_q.push_back(mk(CmdSpareB, 0, 0, 0));
    pending_q.push_back(mk_city(3, 1'b0, 1'b0, 0, 0));
    pending_q.push_back(mk_city(3, 1'b1, 1'b1, 5, 5));
    pending_q.push_back(mk_city(3, 1'b1, 1'b0, 5, 0));
    pending_q.push_back(mk_city(2, 1'b1, 1'b0, 32'hFFFF_FFFF, 1));
    pending_q.push_back(mk_city(63, 1'b0, 1'b0, 0, 0));
    pending_q.push_back(mk_city(4, 1'b1, 1'b0, 1, 32'hFFFF_FFFF));
    pending_q.push_back(mk_city(5, 1'b0, 1'b0, 0, 0));
    pending_q.push_back(mk_city(6, 1'b1, 1'b0, 3, 7));
    pending_q.push_back(mk_city(7, 1'b0, 1'b1, 0, 0));
    pending_q.push_back(mk(pme_pkg::CMD_READ, 6, 7, 0));
    pending_q.push_back(mk(pme_pkg::CMD_READ, 7, 6, 0));
    // self loop: the closing edge is the edge just written
    pending_q.push_back(mk_city(9, 1'b1, 1'b0, 32'h0002_0000, 32'h0001_0000));
    pending_q.push_back(mk_city(9, 1'b0, 1'b1, 0, 0));
    pending_q.push_back(mk(pme_pkg::CMD_READ, 9, 9, 0));
    drain();
    foreach (sides[p]) begin
      write_reg(pme_pkg::REG_NUM_CITIES, (p == 1) ? 32'd0 : 32'(sides[p]));
      write_reg(pme_pkg::REG_EVAP_RATE,
                (p == 0) ? 32'h1_FFFF : ((p == 1) ? 32'd0 : $urandom_range(0, 65536)));
      write_reg(pme_pkg::REG_MIN_LEVEL,
                (p == 2) ? 32'hFFFF_FFFF : ((p == 3) ? 32'd0 : $urandom_range(0, 70000)));
      pending_q.push_back(mk(pme_pkg::CMD_FILL, 0, 0, rnd_val()));
      push_random(counts[p], side());
      if (p == 2) begin
        while (pending_q.size() > 40) @(posedge clk);
        hold_send = 1'b1;
        while (expected_q.size() != 0 || in_tvalid) @(posedge clk);
        hold_send = 1'b0;
        push_random(25, side());
      end
      if (p == 3) begin
        // shrink mid tour: start city falls out of range at close
        pending_q.push_back(mk_city(12, 1'b1, 1'b0, 9, 3));
        pending_q.push_back(mk_city(2, 1'b0, 1'b0, 0, 0));
        drain();
        write_reg(pme_pkg::REG_NUM_CITIES, 32'd8);
        pending_q.push_back(mk(pme_pkg::CMD_FILL, 0, 0, 32'h0000_0100));
        pending_q.push_back(mk_city(3, 1'b0, 1'b1, 0, 0));
      end
      drain();
    end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
